/* rtl/core/rsob_pkg.sv */
// rsob_pkg: widths, pipeline depth and control types of the source-over blender
package rsob_pkg;

  // channel precision, all-ones code stands for 1.0
  localparam int CB    = 8;
  localparam int FULL  = (1 << CB) - 1;

  // product widths through the datapath
  localparam int PW    = 2 * CB;      // weight products and output alpha in FULL^2 units
  localparam int TW    = 3 * CB;      // numerator terms
  localparam int NW    = TW + 1;      // doubled numerator plus rounding term
  localparam int DW    = PW + 1;      // doubled divisor
  localparam int QW    = CB + 1;      // quotient bits before clamping

  // three arithmetic stages, then one restoring step per quotient bit
  localparam int NSTG  = 3 + QW;

  // red, green, blue, alpha
  localparam int NLANE = 4;
  localparam int LANE_ALPHA = 3;

  // divisor of the alpha lane: FULL^2
  localparam logic [PW-1:0] ALPHA_DIV = PW'(FULL * FULL);

  // per-stage control that travels alongside the lane payload
  typedef struct packed {
    logic vld;   // stage holds a transaction
    logic byp;   // transparent foreground, background passes through
  } ctl_t;

endpackage

/* rtl/core/rsob_front.sv */
// rsob_front: shared alpha weights and output alpha in FULL^2 units
module rsob_front import rsob_pkg::*; (
  input  logic          clk,
  input  logic [1:0]    en,
  input  logic [CB-1:0] fa,
  input  logic [CB-1:0] ba,
  output logic [PW-1:0] bainv,
  output logic [PW-1:0] den
);

  logic [PW-1:0] fa_full;

  // stage 1: fa*FULL as shift and subtract, ba*(FULL-fa) on the multiplier
  always_ff @(posedge clk) begin
    if (en[0]) begin
      fa_full <= {fa, {CB{1'b0}}} - PW'(fa);
      bainv   <= PW'(ba) * PW'(CB'(FULL) - fa);
    end
  end

  // stage 2: combined alpha, never above FULL^2
  always_ff @(posedge clk) begin
    if (en[1]) begin
      den <= fa_full + bainv;
    end
  end

endmodule

/* rtl/core/rsob_lane.sv */
// rsob_lane: one channel, weighted numerator and a pipelined rounding divider
module rsob_lane import rsob_pkg::*; (
  input  logic            clk,
  input  logic [NSTG-1:0] en,
  input  logic [CB-1:0]   fa,
  input  logic [CB-1:0]   fc,
  input  logic [CB-1:0]   bc,
  input  logic [CB-1:0]   pass_in,
  input  logic [PW-1:0]   bainv,
  input  logic [PW-1:0]   div,
  output logic [QW-1:0]   quo,
  output logic [CB-1:0]   pass_out
);

  logic [PW-1:0] fafc;
  logic [CB-1:0] bc1;
  logic [CB-1:0] pass1;
  logic [TW-1:0] t1;
  logic [TW-1:0] t2;
  logic [CB-1:0] pass2;
  logic [TW-1:0] num;

  logic [NW-1:0] rem  [QW];
  logic [DW-1:0] dv   [QW];
  logic [QW-1:0] q    [QW+1];
  logic [CB-1:0] ps   [QW+1];

  // stage 1: foreground weight times color
  always_ff @(posedge clk) begin
    if (en[0]) begin
      fafc  <= PW'(fa) * PW'(fc);
      bc1   <= bc;
      pass1 <= pass_in;
    end
  end

  // stage 2: scale foreground term by FULL, background weight times color
  always_ff @(posedge clk) begin
    if (en[1]) begin
      t1    <= {fafc, {CB{1'b0}}} - TW'(fafc);
      t2    <= TW'(bainv) * TW'(bc1);
      pass2 <= pass1;
    end
  end

  // stage 3: round to nearest as (2*num + div) / (2*div)
  assign num = t1 + t2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rem[0] <= {num, 1'b0} + NW'(div);
      dv[0]  <= {div, 1'b0};
      q[0]   <= '0;
      ps[0]  <= pass2;
    end
  end

  // restoring division, one quotient bit per stage, msb first
  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int K = QW - 1 - j;
    logic [NW-1:0] dsh;
    logic          ge;

    assign dsh = NW'(dv[j]) << K;
    assign ge  = rem[j] >= dsh;

    always_ff @(posedge clk) begin
      if (en[3+j]) begin
        q[j+1]  <= {q[j][QW-2:0], ge};
        ps[j+1] <= ps[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[3+j]) begin
          rem[j+1] <= ge ? rem[j] - dsh : rem[j];
          dv[j+1]  <= dv[j];
        end
      end
    end
  end

  assign quo      = q[QW];
  assign pass_out = ps[QW];

endmodule

/* rtl/core/rsob_merge.sv */
// rsob_merge: clamps lane quotients, selects pass-through, drives the output register
module rsob_merge import rsob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_t                  ctl,
  input  logic [QW-1:0]         quo  [NLANE],
  input  logic [CB-1:0]         pass [NLANE],
  input  logic                  m_tready,
  output logic                  adv,
  output logic                  m_tvalid,
  output logic [NLANE*CB-1:0]   m_tdata
);

  logic [NLANE*CB-1:0] data_next;

  // output register takes a new transaction when empty or being drained
  assign adv = !m_tvalid || m_tready;

  // clamp each quotient, transparent foreground keeps the background pixel
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (ctl.byp) begin
        data_next[i*CB +: CB] = pass[i];
      end else if (quo[i] > QW'(FULL)) begin
        data_next[i*CB +: CB] = CB'(FULL);
      end else begin
        data_next[i*CB +: CB] = quo[i][CB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ctl.vld) begin
      m_tdata <= data_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    adv && ctl.vld |=> m_tvalid)
    else $error("finished transaction not presented");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    adv && !ctl.vld |=> !m_tvalid)
    else $error("output valid without a finished transaction");
`endif

endmodule

/* rtl/core/rgba_source_over_blend.sv */
// An accepted transaction reaches m_tvalid through 3 multiply/sum stages,
// 9 restoring divider steps and 1 output register.
// Throughput: one pixel pair per cycle; stalls collapse bubbles stage by stage,
// so input is taken while a result waits as long as any stage is empty.
// Reset: synchronous, clears the stage control bits (valid, bypass) and m_tvalid only.
// Four lanes (red, green, blue, alpha) share the alpha weights of one front unit.
module rgba_source_over_blend import rsob_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // fg_red, fg_green, fg_blue, fg_alpha, bg_red, bg_green, bg_blue, bg_alpha
  input  logic [8*CB-1:0]     s_tdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [NLANE*CB-1:0] m_tdata
);

  logic [CB-1:0]   fc    [NLANE];
  logic [CB-1:0]   bc    [NLANE];
  logic [CB-1:0]   pin   [NLANE];
  logic [PW-1:0]   dvin  [NLANE];
  logic [QW-1:0]   quo   [NLANE];
  logic [CB-1:0]   pout  [NLANE];
  logic [CB-1:0]   fa;
  logic [CB-1:0]   ba;
  logic [PW-1:0]   bainv;
  logic [PW-1:0]   den;
  logic [NSTG:0]   en;
  logic            adv;
  ctl_t            ctl   [NSTG];

  assign fa = s_tdata[3*CB +: CB];
  assign ba = s_tdata[7*CB +: CB];

  // lane operands: color lanes divide by the combined alpha,
  // the alpha lane sees full colors and divides by FULL^2
  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      if (i == LANE_ALPHA) begin
        fc[i]   = CB'(FULL);
        bc[i]   = CB'(FULL);
        pin[i]  = ba;
        dvin[i] = ALPHA_DIV;
      end else begin
        fc[i]   = s_tdata[i*CB +: CB];
        bc[i]   = s_tdata[(4+i)*CB +: CB];
        pin[i]  = s_tdata[(4+i)*CB +: CB];
        dvin[i] = den;
      end
    end
  end

  // stage enables: a stage moves when empty or when the next one moves
  assign en[NSTG] = adv;
  for (genvar i = 0; i < NSTG; i++) begin : g_en
    assign en[i] = !ctl[i].vld || en[i+1];
  end

  assign s_tready = en[0];

  // control pipeline alongside the lanes
  for (genvar i = 0; i < NSTG; i++) begin : g_ctl
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl[0] <= '0;
        end else if (en[0]) begin
          ctl[0] <= '{vld: s_tvalid, byp: (fa == '0)};
        end
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl[i] <= '0;
        end else if (en[i]) begin
          ctl[i] <= ctl[i-1];
        end
      end
    end
  end

  rsob_front u_front (
    .clk   (clk),
    .en    (en[1:0]),
    .fa    (fa),
    .ba    (ba),
    .bainv (bainv),
    .den   (den)
  );

  for (genvar i = 0; i < NLANE; i++) begin : g_lane
    rsob_lane u_lane (
      .clk      (clk),
      .en       (en[NSTG-1:0]),
      .fa       (fa),
      .fc       (fc[i]),
      .bc       (bc[i]),
      .pass_in  (pin[i]),
      .bainv    (bainv),
      .div      (dvin[i]),
      .quo      (quo[i]),
      .pass_out (pout[i])
    );
  end

  rsob_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl[NSTG-1]),
    .quo      (quo),
    .pass     (pout),
    .m_tready (m_tready),
    .adv      (adv),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata)
  );

`ifndef NO_ASSERTIONS
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> ctl[0].vld)
    else $error("accepted transaction lost at pipeline entry");

  a_bubble_ready: assert property (@(posedge clk) disable iff (rst)
    !ctl[0].vld |-> s_tready)
    else $error("input stalled although first stage is empty");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    ctl[NSTG-1].vld && !adv |=> ctl[NSTG-1].vld && $stable(ctl[NSTG-1].byp))
    else $error("last stage dropped a stalled transaction");
`endif

endmodule

/* verif/tb_top.sv */
// tb_top: self-checking stream testbench for the rgba_source_over_blend pixel compositor
module tb_top;
  import rsob_pkg::*;

  // one input transaction, fg_red in the lowest bits of s_tdata
  typedef struct packed {
    logic [CB-1:0] bg_alpha;
    logic [CB-1:0] bg_blue;
    logic [CB-1:0] bg_green;
    logic [CB-1:0] bg_red;
    logic [CB-1:0] fg_alpha;
    logic [CB-1:0] fg_blue;
    logic [CB-1:0] fg_green;
    logic [CB-1:0] fg_red;
  } pixel_pair_t;

  // one composited pixel, out_red in the lowest bits of m_tdata
  typedef struct packed {
    logic [CB-1:0] alpha;
    logic [CB-1:0] blue;
    logic [CB-1:0] green;
    logic [CB-1:0] red;
  } pixel_t;

  typedef enum int {
    PATH_CLEAR_FG  = 0,
    PATH_OPAQUE_BG = 1,
    PATH_GENERAL   = 2
  } blend_path_e;

  localparam int IDLE_LIMIT = 2000;

  // expected composites in arrival order, plus the source-over predictor
  class blend_scoreboard;
    pixel_t      expected_pixels[$];
    int unsigned pairs_seen;
    int unsigned pixels_checked;
    int unsigned mismatches;
    int unsigned path_hits[3];

    // rounded quotient, clamped to the all-ones code
    function automatic logic [CB-1:0] round_div(longint unsigned num, longint unsigned den);
      longint unsigned q;
      if (den == 0) return CB'(FULL);
      q = (2 * num + den) / (2 * den);
      return (q > FULL) ? CB'(FULL) : CB'(q);
    endfunction

    function automatic blend_path_e path_of(pixel_pair_t p);
      if (p.fg_alpha == 0) return PATH_CLEAR_FG;
      if (p.bg_alpha == CB'(FULL)) return PATH_OPAQUE_BG;
      return PATH_GENERAL;
    endfunction

    function automatic pixel_t blend_pixel(pixel_pair_t p);
      longint unsigned fc[3];
      longint unsigned bc[3];
      longint unsigned fa;
      longint unsigned ba;
      longint unsigned inv;
      longint unsigned den;
      logic [CB-1:0]   ch[3];
      pixel_t          r;
      fc[0] = p.fg_red;
      fc[1] = p.fg_green;
      fc[2] = p.fg_blue;
      bc[0] = p.bg_red;
      bc[1] = p.bg_green;
      bc[2] = p.bg_blue;
      fa    = p.fg_alpha;
      ba    = p.bg_alpha;
      inv   = FULL - fa;
      case (path_of(p))
        // clear foreground: background passes through untouched
        PATH_CLEAR_FG: begin
          for (int i = 0; i < 3; i++) ch[i] = CB'(bc[i]);
          r.alpha = p.bg_alpha;
        end
        // opaque background: plain weighted mix, alpha stays full
        PATH_OPAQUE_BG: begin
          for (int i = 0; i < 3; i++) ch[i] = round_div(fa * fc[i] + inv * bc[i], FULL);
          r.alpha = CB'(FULL);
        end
        // general case: normalize by the composite alpha
        default: begin
          den = fa * FULL + ba * inv;
          for (int i = 0; i < 3; i++)
            ch[i] = round_div(fa * fc[i] * FULL + ba * inv * bc[i], den);
          r.alpha = round_div(den, FULL);
        end
      endcase
      r.red   = ch[0];
      r.green = ch[1];
      r.blue  = ch[2];
      return r;
    endfunction

    function void note_pair(pixel_pair_t p);
      expected_pixels.push_back(blend_pixel(p));
      path_hits[path_of(p)]++;
      pairs_seen++;
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output pixel r=%h g=%h b=%h a=%h",
                   got.red, got.green, got.blue, got.alpha);
        return;
      end
      want = expected_pixels.pop_front();
      pixels_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel %0d expected r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                   pixels_checked, want.red, want.green, want.blue, want.alpha,
                   got.red, got.green, got.blue, got.alpha);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [8*CB-1:0]     s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [NLANE*CB-1:0] m_tdata;

  blend_scoreboard sb = new();
  bit              calm = 1'b0;
  int unsigned     idle_cycles = 0;

  rgba_source_over_blend dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // 10 unit clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // channel value that favors the end codes
  function automatic logic [CB-1:0] rand_chan();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CB'(FULL);
      default: return CB'($urandom_range(0, FULL));
    endcase
  endfunction

  function automatic pixel_pair_t make_pair(int fr, int fg, int fb, int fa,
                                            int br, int bg, int bb, int ba);
    pixel_pair_t p;
    p.fg_red   = CB'(fr);
    p.fg_green = CB'(fg);
    p.fg_blue  = CB'(fb);
    p.fg_alpha = CB'(fa);
    p.bg_red   = CB'(br);
    p.bg_green = CB'(bg);
    p.bg_blue  = CB'(bb);
    p.bg_alpha = CB'(ba);
    return p;
  endfunction

  // random pair, steered toward each blend path and the alpha extremes
  function automatic pixel_pair_t random_pair();
    pixel_pair_t p;
    p = make_pair(rand_chan(), rand_chan(), rand_chan(), rand_chan(),
                  rand_chan(), rand_chan(), rand_chan(), rand_chan());
    case ($urandom_range(0, 19))
      0, 1, 2: p.fg_alpha = '0;
      3, 4, 5: p.bg_alpha = CB'(FULL);
      6, 7:    p.fg_alpha = CB'(FULL);
      8:       p.fg_alpha = CB'($urandom_range(1, 3));
      9:       p.bg_alpha = '0;
      default: ;
    endcase
    return p;
  endfunction

  // present one transaction, with an optional idle burst ahead of it;
  // ready is sampled in the low phase, where it is settled for the coming edge
  task automatic send_pair(pixel_pair_t p, bit allow_gap);
    bit hit;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    do begin
      @(negedge clk);
      hit = s_tready;
      @(posedge clk);
    end while (!hit);
  endtask

  // watch both sides of the stream
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_pair(pixel_pair_t'(s_tdata));
      if (m_tvalid && m_tready) sb.check_pixel(pixel_t'(m_tdata));
    end
  end

  // no transaction for too long means a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // output back-pressure in random bursts, none in the calm tail
  initial begin : sink_pacing
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    send_pair(make_pair(255, 255, 255, 255, 255, 255, 255, 255), 1'b1);
    send_pair(make_pair(255, 255, 255, 0, 12, 200, 77, 128), 1'b1);
    send_pair(make_pair(9, 8, 7, 0, 255, 0, 255, 0), 1'b1);
    send_pair(make_pair(1, 2, 3, 0, 40, 50, 60, 255), 1'b1);
    send_pair(make_pair(200, 100, 50, 255, 0, 0, 0, 255), 1'b1);
    send_pair(make_pair(255, 0, 128, 128, 0, 255, 127, 255), 1'b1);
    send_pair(make_pair(255, 255, 255, 1, 0, 0, 0, 255), 1'b1);
    send_pair(make_pair(0, 0, 0, 254, 255, 255, 255, 255), 1'b1);
    send_pair(make_pair(10, 20, 30, 255, 90, 91, 92, 0), 1'b1);
    send_pair(make_pair(10, 20, 30, 255, 90, 91, 92, 100), 1'b1);
    send_pair(make_pair(255, 128, 0, 1, 0, 0, 0, 0), 1'b1);
    send_pair(make_pair(0, 128, 255, 1, 255, 255, 255, 254), 1'b1);
    send_pair(make_pair(255, 0, 255, 128, 0, 255, 0, 128), 1'b1);
    send_pair(make_pair(100, 150, 200, 64, 200, 150, 100, 1), 1'b1);
    send_pair(make_pair(255, 255, 255, 2, 0, 0, 0, 253), 1'b1);
    send_pair(make_pair(3, 250, 127, 170, 251, 4, 129, 85), 1'b1);
    send_pair(make_pair(0, 0, 0, 255, 255, 255, 255, 254), 1'b1);
    send_pair(make_pair(255, 255, 255, 127, 255, 255, 255, 127), 1'b1);
    send_pair(make_pair(85, 170, 85, 254, 170, 85, 170, 1), 1'b1);

    // random pairs, the tail without any idling
    for (int n = 0; n < 1150; n++) begin
      calm = (n >= 1000);
      send_pair(random_pair(), !calm);
    end
    s_tvalid <= 1'b0;

    // drain, then allow for stray late outputs
    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (2 * NSTG) @(posedge clk);

    $display("blend run: %0d pixel pairs sent, %0d composites checked, %0d mismatches",
             sb.pairs_seen, sb.pixels_checked, sb.mismatches);
    $display("paths hit: %0d clear foreground, %0d opaque background, %0d general",
             sb.path_hits[PATH_CLEAR_FG], sb.path_hits[PATH_OPAQUE_BG],
             sb.path_hits[PATH_GENERAL]);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
